// ----- design/mlie_pkg.sv -----
`timescale 1ns / 1ps

package mlie_pkg;

  // line store geometry
  localparam int LINE_DEPTH = 64;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

  // field widths of the work items
  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 6;
  localparam int MODE_W  = 2;
  localparam int OLEN_W  = 7;
  localparam int TICK_W  = 16;
  localparam int MAXL_W  = 7;

  // stream and register port widths
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 32;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // echo sequencing
  localparam int ECHO_W   = 4;
  localparam int TMSG_LEN = 12;

  // control bytes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // register reset values
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd30000;
  localparam logic [7:0]        MASK_RST    = 8'h2A;
  localparam logic [MAXL_W-1:0] MAXL_RST    = 7'd64;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_MASK    = 2'd1,
    REG_MAXLEN  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_BYTE   = 3'd1,
    CMD_TICK   = 3'd2,
    CMD_CANCEL = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_RCVD = 2'd2,
    MODE_CANC = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ECHO_NONE    = 3'd0,
    ECHO_CRLF    = 3'd1,
    ECHO_ERASE   = 3'd2,
    ECHO_MASK    = 3'd3,
    ECHO_TIMEOUT = 3'd4
  } echo_kind_e;

  typedef struct packed {
    logic [TICK_W-1:0] timeout;
    logic [7:0]        mask;
    logic [MAXL_W-1:0] max_len;
  } cfg_t;

  // one classified item, waiting for the back end
  typedef struct packed {
    echo_kind_e       kind;
    logic [7:0]       mask;
    mode_e            mode;
    logic [LEN_W-1:0] len;
    logic             rvalid;
    logic [7:0]       rchar;
  } job_t;

  typedef struct packed {
    logic            empty;
    logic [QCW-1:0]  cnt;
  } q_stat_t;

  localparam logic [7:0] TIMEOUT_MSG [TMSG_LEN] = '{
    8'h0A, 8'h5B, 8'h54, 8'h49, 8'h4D, 8'h45,
    8'h4F, 8'h55, 8'h54, 8'h5D, 8'h0D, 8'h0A
  };

  function automatic logic [ECHO_W-1:0] echo_len(echo_kind_e kind);
    logic [ECHO_W-1:0] n;
    case (kind)
      ECHO_CRLF:    n = 4'd2;
      ECHO_ERASE:   n = 4'd3;
      ECHO_MASK:    n = 4'd1;
      ECHO_TIMEOUT: n = 4'(TMSG_LEN);
      default:      n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] echo_byte(echo_kind_e kind, logic [ECHO_W-1:0] k,
                                           logic [7:0] mask);
    logic [7:0] b;
    case (kind)
      ECHO_CRLF:    b = (k == 4'd0) ? CH_CR : CH_LF;
      ECHO_ERASE:   b = (k == 4'd1) ? CH_SPACE : CH_BS;
      ECHO_MASK:    b = mask;
      ECHO_TIMEOUT: b = (32'(k) < TMSG_LEN) ? TIMEOUT_MSG[k] : 8'h00;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- design/masked_line_input_editor_unit.sv -----
`timescale 1ns / 1ps

// channel   | dir | handshake                   | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tuser cmd; tdata data_byte, read_index
// m_axis    | out | m_axis_tvalid/m_axis_tready | tuser is_echo; tlast last; tdata status
// apb       | in  | psel/penable, pready high   | timeout_ticks, mask_char, max_length
//
// The front end takes one item per cycle while the four-entry job queue has room;
// every item then passes the front's store read stage, counted against that room.
// The back end sends one result per cycle while the receiver is ready; each item gives
// its echo bytes (12 for the timeout message), then a status, set by the echo sequencer.
// Reset is asynchronous and active low; the line store itself is not cleared.
// A stalled output only backs up the queue, so the input keeps flowing until it fills.
module masked_line_input_editor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] data_byte, [13:8] read_index, [15:14] zero
  input  logic [mlie_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [2:0] cmd
  input  logic [mlie_pkg::CMD_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] echo_byte, [9:8] mode, [16:10] line_length, [24:17] read_char,
  // [25] read_valid, [31:26] zero
  output logic [mlie_pkg::M_DATA_W-1:0] m_axis_tdata,
  // [0] is_echo
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlie_pkg::APB_AW-1:0]   paddr,
  input  logic [mlie_pkg::APB_DW-1:0]   pwdata,
  output logic [mlie_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mlie_pkg::*;

  cfg_t      cfg_q;
  logic      cfg_we;
  reg_idx_e  reg_idx;
  job_t      push_job;
  job_t      head_job;
  logic      push;
  logic      pop;
  q_stat_t   q_stat;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout <= TIMEOUT_RST;
      cfg_q.mask    <= MASK_RST;
      cfg_q.max_len <= MAXL_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_TIMEOUT: cfg_q.timeout <= pwdata[TICK_W-1:0];
        REG_MASK:    cfg_q.mask    <= pwdata[7:0];
        REG_MAXLEN:  cfg_q.max_len <= pwdata[MAXL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_TIMEOUT: prdata = {{(APB_DW-TICK_W){1'b0}}, cfg_q.timeout};
      REG_MASK:    prdata = {24'd0, cfg_q.mask};
      REG_MAXLEN:  prdata = {{(APB_DW-MAXL_W){1'b0}}, cfg_q.max_len};
      default:     prdata = '0;
    endcase
  end

  mlie_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_byte_i  (s_axis_tdata[7:0]),
    .in_idx_i   (s_axis_tdata[13:8]),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  mlie_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  mlie_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_job),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_is_echo_o (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

endmodule

// ----- design/mlie_ram.sv -----
`timescale 1ns / 1ps

module mlie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/mlie_front.sv -----
`timescale 1ns / 1ps

module mlie_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mlie_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mlie_pkg::CMD_W-1:0]        in_cmd_i,
  input  logic [mlie_pkg::BYTE_W-1:0]       in_byte_i,
  input  logic [mlie_pkg::IDX_W-1:0]        in_idx_i,
  input  mlie_pkg::q_stat_t                 q_stat_i,
  output logic                              push_o,
  output mlie_pkg::job_t                    job_o
);
  import mlie_pkg::*;

  mode_e             mode_q, mode_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;
  logic              consumed_q, consumed_d;

  logic              accept;
  logic              ram_we;
  logic [LINE_AW-1:0] ram_addr;
  logic [7:0]        ram_rdata;
  logic [TICK_W-1:0] elapsed_inc;
  logic [IDX_W+LINE_AW-1:0] idx_wide;

  job_t              job_d;
  logic              hit_d;
  logic              s1_v_q;
  job_t              s1_job_q;
  logic              s1_hit_q;

  // room for the item in flight and this one
  assign in_ready_o = (32'(q_stat_i.cnt) + 32'(s1_v_q)) < QDEPTH;
  assign accept     = in_valid_i && in_ready_o;

  assign elapsed_inc = (in_cmd_i == CMD_TICK && elapsed_q != '1) ? elapsed_q + 1'b1
                                                                  : elapsed_q;
  assign idx_wide    = {{LINE_AW{1'b0}}, in_idx_i};

  // classify the item and work out the next line state
  always_comb begin
    mode_d     = mode_q;
    len_d      = len_q;
    elapsed_d  = elapsed_q;
    consumed_d = consumed_q;
    ram_we     = 1'b0;
    ram_addr   = idx_wide[LINE_AW-1:0];
    job_d.kind = ECHO_NONE;
    job_d.mask = cfg_i.mask;
    job_d.rvalid = 1'b0;
    job_d.rchar  = 8'h00;
    hit_d      = 1'b0;
    case (cmd_e'(in_cmd_i))
      CMD_START: begin
        mode_d     = MODE_WAIT;
        len_d      = '0;
        consumed_d = 1'b0;
        elapsed_d  = '0;
      end
      CMD_BYTE, CMD_TICK: begin
        if (consumed_q && mode_q == MODE_RCVD) begin
          mode_d = MODE_IDLE;
        end else if (mode_q == MODE_WAIT) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= cfg_i.timeout) begin
            mode_d     = MODE_CANC;
            len_d      = '0;
            consumed_d = 1'b0;
            job_d.kind = ECHO_TIMEOUT;
          end else if (in_cmd_i == CMD_BYTE) begin
            if (in_byte_i == CH_LF || in_byte_i == CH_CR) begin
              mode_d     = MODE_RCVD;
              job_d.kind = ECHO_CRLF;
            end else if (in_byte_i == CH_BS || in_byte_i == CH_DEL) begin
              if (len_q != '0) begin
                len_d      = len_q - 1'b1;
                job_d.kind = ECHO_ERASE;
              end
            end else if (in_byte_i >= CH_SPACE) begin
              if (32'(len_q) < 32'(cfg_i.max_len) && 32'(len_q) < LINE_DEPTH) begin
                ram_we     = 1'b1;
                ram_addr   = len_q[LINE_AW-1:0];
                len_d      = len_q + 1'b1;
                job_d.kind = ECHO_MASK;
              end
            end
          end
        end
      end
      CMD_CANCEL: begin
        mode_d     = MODE_CANC;
        len_d      = '0;
        consumed_d = 1'b0;
      end
      CMD_READ: begin
        if (mode_q == MODE_RCVD) begin
          consumed_d   = 1'b1;
          job_d.rvalid = 1'b1;
          hit_d        = 32'(in_idx_i) < 32'(len_q);
        end
      end
      default: begin
      end
    endcase
    job_d.mode = mode_d;
    job_d.len  = len_d;
  end

  mlie_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (accept && ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_byte_i),
    .rdata_o (ram_rdata)
  );

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      len_q      <= '0;
      elapsed_q  <= '0;
      consumed_q <= 1'b0;
      s1_v_q     <= 1'b0;
    end else begin
      s1_v_q <= accept;
      if (accept) begin
        mode_q     <= mode_d;
        len_q      <= len_d;
        elapsed_q  <= elapsed_d;
        consumed_q <= consumed_d;
      end
    end
  end

  // second stage waits for the store read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_job_q <= job_d;
      s1_hit_q <= hit_d;
    end
  end

  always_comb begin
    job_o       = s1_job_q;
    job_o.rchar = s1_hit_q ? ram_rdata : 8'h00;
  end

  assign push_o = s1_v_q;

endmodule

// ----- design/mlie_queue.sv -----
`timescale 1ns / 1ps

module mlie_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mlie_pkg::job_t    push_job_i,
  input  logic              pop_i,
  output mlie_pkg::job_t    head_o,
  output mlie_pkg::q_stat_t stat_o
);
  import mlie_pkg::*;

  job_t            slot_q [QDEPTH];
  logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]  cnt_q;
  logic            full;

  assign full         = 32'(cnt_q) == QDEPTH;
  assign stat_o.empty = cnt_q == '0;
  assign stat_o.cnt   = cnt_q;
  assign head_o       = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full && !pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty))
    else $error("queue pop while empty");

endmodule

// ----- design/mlie_back.sv -----
`timescale 1ns / 1ps

module mlie_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mlie_pkg::job_t                head_i,
  input  mlie_pkg::q_stat_t             q_stat_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mlie_pkg::M_DATA_W-1:0] out_data_o,
  output logic                          out_is_echo_o,
  output logic                          out_last_o
);
  import mlie_pkg::*;

  logic [ECHO_W-1:0] k_q, k_d;
  logic              out_v_q, out_v_d;
  logic              load;
  logic              emit;
  logic              is_status;
  logic [ECHO_W-1:0] n_echo;

  logic              is_echo_q;
  logic [7:0]        echo_q;
  logic [MODE_W-1:0] mode_q;
  logic [OLEN_W-1:0] len_q;
  logic [7:0]        rchar_q;
  logic              rvalid_q;
  logic              last_q;

  assign n_echo    = echo_len(head_i.kind);
  assign load      = !out_v_q || out_ready_i;
  assign emit      = load && !q_stat_i.empty;
  assign is_status = k_q == n_echo;
  assign pop_o     = emit && is_status;

  // echo position and output valid
  always_comb begin
    k_d     = k_q;
    out_v_d = out_v_q;
    if (load) begin
      out_v_d = emit;
    end
    if (emit) begin
      k_d = is_status ? '0 : k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      k_q     <= k_d;
      out_v_q <= out_v_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      is_echo_q <= !is_status;
      echo_q    <= is_status ? 8'h00 : echo_byte(head_i.kind, k_q, head_i.mask);
      mode_q    <= head_i.mode;
      len_q     <= OLEN_W'(head_i.len);
      rchar_q   <= is_status ? head_i.rchar : 8'h00;
      rvalid_q  <= is_status && head_i.rvalid;
      last_q    <= is_status;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_is_echo_o = is_echo_q;
  assign out_last_o    = last_q;
  assign out_data_o    = {6'd0, rvalid_q, rchar_q, len_q, mode_q, echo_q};

  a_pop_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_v_q && last_q && !is_echo_q)
    else $error("status not loaded when job retired");

  a_echo_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat_i.empty |-> k_q <= n_echo)
    else $error("echo position past job length");

endmodule

// ----- tb/masked_line_input_editor_unit_test.sv -----
`timescale 1ns / 1ps

module masked_line_input_editor_unit_test;
  import mlie_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int STALL_CYCLES = 300;
  localparam int PHASE_ITEMS  = 70;
  // a command code that the block must pass through untouched
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  // one result transaction as the block should send it
  typedef struct packed {
    logic              is_echo;
    logic [7:0]        echo;
    mode_e             mode;
    logic [OLEN_W-1:0] len;
    logic [7:0]        rchar;
    logic              rvalid;
    logic              last;
  } line_result_t;

  // one row of the directed table: a register write or an input item
  typedef struct packed {
    logic              wr;
    reg_idx_e          sel;
    logic [15:0]       val;
    logic [CMD_W-1:0]  cmd;
    logic [7:0]        b;
    logic [IDX_W-1:0]  idx;
    logic              typed;
    mode_e             t_mode;
    logic [OLEN_W-1:0] t_len;
    logic [7:0]        t_rchar;
    logic              t_rvalid;
  } plan_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [CMD_W-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  masked_line_input_editor_unit dut (.*);

  // editor state as predicted
  mode_e             ed_mode     = MODE_IDLE;
  logic [7:0]        line_copy [LINE_DEPTH];
  int unsigned       line_len    = 0;
  int unsigned       tick_count  = 0;
  bit                consumed    = 1'b0;
  logic [TICK_W-1:0] cfg_timeout = TIMEOUT_RST;
  logic [7:0]        cfg_mask    = MASK_RST;
  logic [MAXL_W-1:0] cfg_maxlen  = MAXL_RST;
  line_result_t      awaited_results[$];

  int  src_idle_pct  = 0;
  int  snk_idle_pct  = 0;
  bit  stall_request = 1'b0;
  int  fail_count    = 0;
  int  n_items       = 0;
  int  n_results     = 0;
  int  n_lines       = 0;
  int  n_timeouts    = 0;
  int  n_valid_reads = 0;

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h (result %0d)",
             $time, what, got, want, n_results);
    fail_count++;
  endtask

  // work out the results of one accepted item and advance the predicted state
  function automatic void edit_line(input logic [CMD_W-1:0] cmd, input logic [7:0] b,
                                    input logic [IDX_W-1:0] idx);
    logic [7:0]   echoes[$];
    logic [7:0]   rchar;
    logic         rvalid;
    int unsigned  limit;
    string        note;
    line_result_t res;
    note   = "[TIMEOUT]";
    rchar  = 8'h00;
    rvalid = 1'b0;
    limit  = (cfg_maxlen > LINE_DEPTH) ? LINE_DEPTH : cfg_maxlen;
    case (cmd)
      CMD_START: begin
        line_len   = 0;
        consumed   = 1'b0;
        tick_count = 0;
        ed_mode    = MODE_WAIT;
      end
      CMD_BYTE, CMD_TICK: begin
        if (consumed && ed_mode == MODE_RCVD) begin
          ed_mode = MODE_IDLE;
        end else if (ed_mode == MODE_WAIT) begin
          if (cmd == CMD_TICK && tick_count < 16'hFFFF) tick_count++;
          // timeout wins over the byte itself
          if (tick_count >= cfg_timeout) begin
            echoes.push_back(CH_LF);
            for (int i = 0; i < note.len(); i++) echoes.push_back(note[i]);
            echoes.push_back(CH_CR);
            echoes.push_back(CH_LF);
            ed_mode  = MODE_CANC;
            line_len = 0;
            consumed = 1'b0;
            n_timeouts++;
          end else if (cmd == CMD_BYTE) begin
            if (b == CH_LF || b == CH_CR) begin
              echoes.push_back(CH_CR);
              echoes.push_back(CH_LF);
              ed_mode = MODE_RCVD;
              n_lines++;
            end else if (b == CH_BS || b == CH_DEL) begin
              if (line_len > 0) begin
                line_len--;
                echoes.push_back(CH_BS);
                echoes.push_back(CH_SPACE);
                echoes.push_back(CH_BS);
              end
            end else if (b >= CH_SPACE && line_len < limit) begin
              line_copy[line_len] = b;
              line_len++;
              echoes.push_back(cfg_mask);
            end
          end
        end
      end
      CMD_CANCEL: begin
        ed_mode  = MODE_CANC;
        line_len = 0;
        consumed = 1'b0;
      end
      CMD_READ: begin
        if (ed_mode == MODE_RCVD) begin
          consumed = 1'b1;
          rvalid   = 1'b1;
          if (idx < line_len) rchar = line_copy[idx];
          n_valid_reads++;
        end
      end
      default: ;
    endcase
    foreach (echoes[k]) begin
      res = '{1'b1, echoes[k], ed_mode, OLEN_W'(line_len), 8'h00, 1'b0, 1'b0};
      awaited_results.push_back(res);
    end
    res = '{1'b0, 8'h00, ed_mode, OLEN_W'(line_len), rchar, rvalid, 1'b1};
    awaited_results.push_back(res);
  endfunction

  // receiver readiness, with an occasional long hold-off
  always @(posedge clk_i) begin : sink_ready
    int stall_left;
    if (stall_request) begin
      stall_left    = STALL_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    line_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata, 0);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser !== want.is_echo)
          report_mismatch("is_echo", m_axis_tuser, want.is_echo);
        if (m_axis_tdata[7:0] !== want.echo)
          report_mismatch("echo_byte", m_axis_tdata[7:0], want.echo);
        if (m_axis_tdata[9:8] !== want.mode)
          report_mismatch("mode", m_axis_tdata[9:8], want.mode);
        if (m_axis_tdata[16:10] !== want.len)
          report_mismatch("line_length", m_axis_tdata[16:10], want.len);
        if (m_axis_tdata[24:17] !== want.rchar)
          report_mismatch("read_char", m_axis_tdata[24:17], want.rchar);
        if (m_axis_tdata[25] !== want.rvalid)
          report_mismatch("read_valid", m_axis_tdata[25], want.rvalid);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  // end the run if no transaction moves for too long
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                 $time, quiet, awaited_results.size());
        $display("masked_line_input_editor_unit_test NOT OK");
        $finish;
      end
    end
  end

  // offer one item after a random gap and predict it once accepted
  task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [7:0] b,
                            input logic [IDX_W-1:0] idx);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'({idx, b});
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    edit_line(cmd, b, idx);
    n_items++;
  endtask

  // stop offering and wait until every expected result is in
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // register write followed by a read back
  task automatic write_reg(input reg_idx_e sel, input logic [15:0] val);
    logic [APB_DW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({sel, 2'b00});
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_TIMEOUT: cfg_timeout = val;
      REG_MASK:    cfg_mask    = val[7:0];
      REG_MAXLEN:  cfg_maxlen  = val[MAXL_W-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_TIMEOUT: want = APB_DW'(cfg_timeout);
      REG_MASK:    want = APB_DW'(cfg_mask);
      default:     want = APB_DW'(cfg_maxlen);
    endcase
    if (prdata !== want) report_mismatch("register read back", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // random traffic: mostly complete lines, some loose commands
  task automatic run_session(input int count);
    int start_count;
    int nbytes;
    int pick;
    start_count = n_items;
    while (n_items - start_count < count) begin
      if ($urandom_range(0, 99) < 80) begin
        offer_item(CMD_START, 8'($urandom), 6'($urandom));
        nbytes = (cfg_maxlen >= LINE_DEPTH && $urandom_range(0, 7) == 0) ?
                 $urandom_range(60, 72) : $urandom_range(0, 10);
        repeat (nbytes) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)
            offer_item(CMD_BYTE, 8'($urandom_range(32, 255)), 6'($urandom));
          else if (pick < 80)
            offer_item(CMD_BYTE, pick[0] ? CH_BS : CH_DEL, 6'($urandom));
          else if (pick < 88)
            offer_item(CMD_BYTE, 8'($urandom_range(0, 31)), 6'($urandom));
          else
            offer_item(CMD_TICK, 8'($urandom), 6'($urandom));
        end
        // close the line, now and then abandon it
        pick = $urandom_range(0, 99);
        if (pick < 85)
          offer_item(CMD_BYTE, pick[0] ? CH_CR : CH_LF, 6'($urandom));
        else if (pick < 93)
          offer_item(CMD_CANCEL, 8'($urandom), 6'($urandom));
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 1))
            offer_item(CMD_READ, 8'($urandom), 6'($urandom));
          else
            offer_item(CMD_READ, 8'($urandom),
                       6'($urandom_range(0, (line_len > 63) ? 63 : line_len)));
        end
        if ($urandom_range(0, 9) < 7)
          offer_item($urandom_range(0, 1) ? CMD_BYTE : CMD_TICK, 8'($urandom),
                     6'($urandom));
      end else begin
        pick = $urandom_range(0, 19);
        offer_item((pick < 17) ? CMD_W'(pick % 5) : CMD_W'(pick - 12),
                   8'($urandom), 6'($urandom));
      end
    end
  endtask

  task automatic configure(input logic [15:0] timeout, input logic [7:0] mask,
                           input logic [MAXL_W-1:0] maxlen);
    settle();
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_MASK, 16'(mask));
    write_reg(REG_MAXLEN, 16'(maxlen));
  endtask

  function automatic plan_row_t step_row(input logic [CMD_W-1:0] cmd, input logic [7:0] b,
                                         input logic [IDX_W-1:0] idx);
    plan_row_t r;
    r     = '0;
    r.cmd = cmd;
    r.b   = b;
    r.idx = idx;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic [CMD_W-1:0] cmd,
                                            input logic [7:0] b,
                                            input logic [IDX_W-1:0] idx,
                                            input mode_e mode,
                                            input logic [OLEN_W-1:0] len,
                                            input logic [7:0] rchar, input logic rvalid);
    plan_row_t r;
    r          = step_row(cmd, b, idx);
    r.typed    = 1'b1;
    r.t_mode   = mode;
    r.t_len    = len;
    r.t_rchar  = rchar;
    r.t_rvalid = rvalid;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input reg_idx_e sel, input logic [15:0] val);
    plan_row_t r;
    r     = '0;
    r.wr  = 1'b1;
    r.sel = sel;
    r.val = val;
    return r;
  endfunction

  // stimulus
  initial begin : main
    plan_row_t    plan[$];
    line_result_t status;
    plan = '{
      // nothing happens before a start
      checked_row(CMD_READ, 8'h00, 6'd0, MODE_IDLE, 7'd0, 8'h00, 1'b0),
      checked_row(CMD_BYTE, "A", 6'd0, MODE_IDLE, 7'd0, 8'h00, 1'b0),
      checked_row(CMD_UNUSED, 8'hFF, 6'h3F, MODE_IDLE, 7'd0, 8'h00, 1'b0),
      checked_row(CMD_START, 8'h00, 6'd0, MODE_WAIT, 7'd0, 8'h00, 1'b0),
      // erase on an empty line and plain controls are dropped
      checked_row(CMD_BYTE, CH_BS, 6'd0, MODE_WAIT, 7'd0, 8'h00, 1'b0),
      checked_row(CMD_BYTE, 8'h1F, 6'd0, MODE_WAIT, 7'd0, 8'h00, 1'b0),
      step_row(CMD_BYTE, CH_SPACE, 6'd0),
      step_row(CMD_BYTE, 8'hFF, 6'd0),
      step_row(CMD_BYTE, 8'h80, 6'd0),
      step_row(CMD_BYTE, CH_DEL, 6'd0),
      step_row(CMD_BYTE, CH_CR, 6'd0),
      step_row(CMD_READ, 8'h00, 6'd1),
      checked_row(CMD_READ, 8'h00, 6'd63, MODE_RCVD, 7'd2, 8'h00, 1'b1),
      // a consumed line goes idle on the next tick
      checked_row(CMD_TICK, 8'h00, 6'd0, MODE_IDLE, 7'd2, 8'h00, 1'b0),
      // one-character line, zero mask, timeout by ticks
      reg_row(REG_MAXLEN, 16'd1),
      reg_row(REG_MASK, 16'h0000),
      reg_row(REG_TIMEOUT, 16'd2),
      step_row(CMD_START, 8'h00, 6'd0),
      step_row(CMD_BYTE, "a", 6'd0),
      step_row(CMD_BYTE, "b", 6'd0),
      step_row(CMD_TICK, 8'h00, 6'd0),
      checked_row(CMD_TICK, 8'h00, 6'd0, MODE_CANC, 7'd0, 8'h00, 1'b0),
      // lowering the timeout lets a byte cancel
      reg_row(REG_TIMEOUT, 16'd100),
      step_row(CMD_START, 8'h00, 6'd0),
      step_row(CMD_TICK, 8'h00, 6'd0),
      reg_row(REG_TIMEOUT, 16'd1),
      checked_row(CMD_BYTE, "c", 6'd0, MODE_CANC, 7'd0, 8'h00, 1'b0),
      // zero timeout and zero length limit
      reg_row(REG_TIMEOUT, 16'd0),
      reg_row(REG_MAXLEN, 16'd0),
      step_row(CMD_START, 8'h00, 6'd0),
      checked_row(CMD_BYTE, CH_LF, 6'd0, MODE_CANC, 7'd0, 8'h00, 1'b0),
      reg_row(REG_TIMEOUT, 16'hFFFF),
      step_row(CMD_START, 8'h00, 6'd0),
      checked_row(CMD_BYTE, "d", 6'd0, MODE_WAIT, 7'd0, 8'h00, 1'b0),
      checked_row(CMD_CANCEL, 8'h00, 6'd0, MODE_CANC, 7'd0, 8'h00, 1'b0)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    src_idle_pct = 24;
    snk_idle_pct = 51;
    foreach (plan[i]) begin
      if (plan[i].wr) begin
        settle();
        write_reg(plan[i].sel, plan[i].val);
      end else begin
        offer_item(plan[i].cmd, plan[i].b, plan[i].idx);
        if (plan[i].typed) begin
          status        = awaited_results.pop_back();
          status.mode   = plan[i].t_mode;
          status.len    = plan[i].t_len;
          status.rchar  = plan[i].t_rchar;
          status.rvalid = plan[i].t_rvalid;
          awaited_results.push_back(status);
        end
      end
    end

    // random phases under a range of settings
    configure(16'd20, 8'h23, 7'd8);
    run_session(PHASE_ITEMS);
    configure(16'hFFFF, 8'hFF, 7'd64);
    run_session(PHASE_ITEMS);

    src_idle_pct = 51;
    snk_idle_pct = 24;
    configure(16'd1, 8'h00, 7'd1);
    run_session(PHASE_ITEMS / 2);
    settle();
    run_session(PHASE_ITEMS / 2);
    configure(16'd12, 8'hA5, 7'd127);
    run_session(PHASE_ITEMS);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    configure(16'd30, 8'h5A, 7'd3);
    run_session(PHASE_ITEMS / 2);
    stall_request = 1'b1;
    run_session(PHASE_ITEMS / 2);
    configure(16'd8, 8'h2E, 7'd16);
    run_session(PHASE_ITEMS);

    settle();
    repeat (20) @(posedge clk_i);
    $display("covered %0d items and %0d results: %0d lines ended, %0d timeouts, %0d reads",
             n_items, n_results, n_lines, n_timeouts, n_valid_reads);
    $display("register settings from zero up to full scale, one long output stall");
    if (fail_count == 0) begin
      $display("masked_line_input_editor_unit_test OK");
    end else begin
      $display("masked_line_input_editor_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- masked_line_input_editor_unit.f -----
design/mlie_pkg.sv
design/mlie_ram.sv
design/mlie_front.sv
design/mlie_queue.sv
design/mlie_back.sv
design/masked_line_input_editor_unit.sv
tb/masked_line_input_editor_unit_test.sv
